// ===== hw/rtl/stq_pkg.sv =====
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and codes for the sorted timer queue: item and result
// payloads, op and result kind codes, controller/datapath command and status.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int ID_W   = 4;
  localparam int TIME_W = 32;
  localparam int OP_W   = 2;
  localparam int KIND_W = 2;

  // Largest number of distinct timer ids the id field can name
  localparam int MAX_SLOTS = 1 << ID_W;

  // Op codes
  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_DEL = 2'd1;
  localparam logic [OP_W-1:0] OP_RUN = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_ADD_DONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEL_DONE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIRED    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RUN_DONE = 2'd3;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   timer_id;
    logic [TIME_W-1:0] expires;
    logic [TIME_W-1:0] now;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   fired_id;
    logic [TIME_W-1:0] time_left;
    logic              last;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic              capture;   // load item, clamp expiry
    logic              set_mark;  // run mark <= now
    logic              scan_clr;  // scan index <= 0
    logic              scan_inc;  // scan index++
    logic              remove;    // unlink order entry at scan index
    logic              insert;    // link item id at scan index
    logic              emit;      // load result register
    logic [KIND_W-1:0] emit_kind;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            id_valid;   // id names an existing slot
    logic            id_queued;  // that slot is in the queue
    logic            match;      // entry at scan index is the item id
    logic            scan_end;   // scan index reached the queue length
    logic            ins_here;   // insert point found at scan index
    logic            head_due;   // queue head has expired
  } dp_status_t;

endpackage

// ===== hw/rtl/stq_datapath.sv =====
// ----------------------------------------------------------------------------
// stq_datapath
// Queue storage (order list, per-slot expiry and queued flags), run mark,
// scan index, compare logic and the registered result port.
// ----------------------------------------------------------------------------
module stq_datapath #(
  parameter int NUM_TIMERS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  stq_pkg::item_t        item,
  input  stq_pkg::ctrl_cmd_t    cmd,
  output stq_pkg::dp_status_t   status,
  output stq_pkg::result_t      result,
  output logic                  strobe
);

  localparam int SLOTS = (NUM_TIMERS < stq_pkg::MAX_SLOTS) ? NUM_TIMERS : stq_pkg::MAX_SLOTS;
  localparam int IDXW  = $clog2(SLOTS);
  localparam int CNTW  = $clog2(SLOTS + 1);

  stq_pkg::item_t             item_q;
  logic [stq_pkg::TIME_W-1:0] exp_eff;
  logic [stq_pkg::TIME_W-1:0] run_mark;
  logic [stq_pkg::ID_W-1:0]   order  [SLOTS];
  logic [stq_pkg::TIME_W-1:0] expiry [SLOTS];
  logic [SLOTS-1:0]           queued;
  logic [CNTW-1:0]            count;
  logic [CNTW-1:0]            scan;

  logic [IDXW-1:0]            scan_idx;
  logic [IDXW-1:0]            id_idx;
  logic [IDXW-1:0]            head_idx;
  logic [stq_pkg::ID_W-1:0]   scan_id;
  logic [stq_pkg::TIME_W-1:0] scan_exp;
  logic [stq_pkg::TIME_W-1:0] head_exp;
  logic [stq_pkg::TIME_W-1:0] floor_t;
  logic [stq_pkg::TIME_W-1:0] tmo;

  assign scan_idx = scan[IDXW-1:0];
  assign id_idx   = item_q.timer_id[IDXW-1:0];
  assign scan_id  = order[scan_idx];
  assign scan_exp = expiry[scan_id[IDXW-1:0]];
  assign head_idx = order[0][IDXW-1:0];
  assign head_exp = expiry[head_idx];

  // Expiry floor: one past the run mark, saturating
  assign floor_t = (run_mark == stq_pkg::TIME_MAX) ? stq_pkg::TIME_MAX
                                                   : run_mark + stq_pkg::TIME_W'(1);

  // Time to next expiry; an overdue head reports a time left of 1
  always_comb begin
    if (count == '0) begin
      tmo = '0;
    end else if (head_exp > item_q.now) begin
      tmo = head_exp - item_q.now;
    end else begin
      tmo = stq_pkg::TIME_W'(1);
    end
  end

  // Status to controller
  always_comb begin
    status.op        = item_q.op;
    status.id_valid  = (int'(item_q.timer_id) < SLOTS);
    status.id_queued = queued[id_idx];
    status.scan_end  = (scan == count);
    status.match     = (scan_id == item_q.timer_id);
    status.ins_here  = (scan == count) || (exp_eff <= scan_exp);
    status.head_due  = (count != '0) && (head_exp <= item_q.now);
  end

  // Item capture with clamped expiry
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_q  <= item;
      exp_eff <= (item.expires < floor_t) ? floor_t : item.expires;
    end
  end

  // Control state: run mark, count, queued flags, scan index
  always_ff @(posedge clk) begin
    if (rst) begin
      run_mark <= '0;
      count    <= '0;
      queued   <= '0;
      scan     <= '0;
    end else begin
      if (cmd.set_mark) begin
        run_mark <= item_q.now;
      end
      if (cmd.scan_clr) begin
        scan <= '0;
      end else if (cmd.scan_inc) begin
        scan <= scan + CNTW'(1);
      end
      if (cmd.remove) begin
        count                        <= count - CNTW'(1);
        queued[scan_id[IDXW-1:0]]    <= 1'b0;
      end else if (cmd.insert) begin
        count          <= count + CNTW'(1);
        queued[id_idx] <= 1'b1;
      end
    end
  end

  // Order list shifts and expiry writes
  always_ff @(posedge clk) begin
    if (cmd.remove) begin
      for (int j = 0; j < SLOTS - 1; j++) begin
        if (j >= int'(scan)) begin
          order[j] <= order[j+1];
        end
      end
    end else if (cmd.insert) begin
      if (scan == '0) begin
        order[0] <= item_q.timer_id;
      end
      for (int j = 1; j < SLOTS; j++) begin
        if (j == int'(scan)) begin
          order[j] <= item_q.timer_id;
        end else if (j > int'(scan)) begin
          order[j] <= order[j-1];
        end
      end
      expiry[id_idx] <= exp_eff;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.kind      <= cmd.emit_kind;
      result.fired_id  <= (cmd.emit_kind == stq_pkg::KIND_FIRED) ? scan_id : '0;
      result.time_left <= (cmd.emit_kind == stq_pkg::KIND_RUN_DONE) ? tmo : '0;
      result.last      <= (cmd.emit_kind != stq_pkg::KIND_FIRED);
    end
  end

endmodule

// ===== hw/rtl/stq_ctrl.sv =====
// ----------------------------------------------------------------------------
// stq_ctrl
// Sequencer for the timer queue: decodes the op, walks the order list to
// unlink or find the insert point, and drains expired timers on a run.
// ----------------------------------------------------------------------------
module stq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  stq_pkg::dp_status_t  status,
  output stq_pkg::ctrl_cmd_t   cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_FIND   = 5'b00100,
    S_INSERT = 5'b01000,
    S_RUN    = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.scan_clr = 1'b1;
        case (status.op)
          stq_pkg::OP_ADD: begin
            if (status.id_valid && status.id_queued) begin
              state_next = S_FIND;
            end else if (status.id_valid) begin
              state_next = S_INSERT;
            end else begin
              cmd.emit      = 1'b1;
              cmd.emit_kind = stq_pkg::KIND_ADD_DONE;
              state_next    = S_IDLE;
            end
          end
          stq_pkg::OP_DEL: begin
            if (status.id_valid && status.id_queued) begin
              state_next = S_FIND;
            end else begin
              cmd.emit      = 1'b1;
              cmd.emit_kind = stq_pkg::KIND_DEL_DONE;
              state_next    = S_IDLE;
            end
          end
          stq_pkg::OP_RUN: begin
            cmd.set_mark = 1'b1;
            state_next   = S_RUN;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      // Locate the item's timer in the list and unlink it
      S_FIND: begin
        if (status.match || status.scan_end) begin
          cmd.remove   = status.match && !status.scan_end;
          cmd.scan_clr = 1'b1;
          if (status.op == stq_pkg::OP_ADD) begin
            state_next = S_INSERT;
          end else begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = stq_pkg::KIND_DEL_DONE;
            state_next    = S_IDLE;
          end
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      // Walk to the first entry not earlier than the new expiry
      S_INSERT: begin
        if (status.ins_here) begin
          cmd.insert    = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_kind = stq_pkg::KIND_ADD_DONE;
          state_next    = S_IDLE;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      // Pop expired heads one per cycle, then report the timeout
      S_RUN: begin
        cmd.emit = 1'b1;
        if (status.head_due) begin
          cmd.remove    = 1'b1;
          cmd.emit_kind = stq_pkg::KIND_FIRED;
        end else begin
          cmd.emit_kind = stq_pkg::KIND_RUN_DONE;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/sorted_timer_queue_top.sv =====
// ----------------------------------------------------------------------------
// sorted_timer_queue_top
// Timer queue kept sorted by expiry; add, delete and run commands.
// Add walks the list to its insert point, after first walking it to unlink a
//   rescheduled timer; delete walks the list to unlink; run pops each expired
//   timer. The list walk covers one entry per cycle.
// One item at a time; results arrive one per cycle and cannot be held off.
// Synchronous reset empties the queue and clears the run mark.
// ----------------------------------------------------------------------------
module sorted_timer_queue_top #(
  parameter int NUM_TIMERS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  stq_pkg::item_t   item,
  output stq_pkg::result_t result,
  output logic             strobe
);

  stq_pkg::ctrl_cmd_t  cmd;
  stq_pkg::dp_status_t status;

  stq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  stq_datapath #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .result (result),
    .strobe (strobe)
  );

  // An accepted transfer always leaves the sequencer busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not start the sequencer");

  // The final result of an item finds the sequencer idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |-> !busy)
    else $error("final result while still busy");

  // A fired timer is always followed by another result
  a_fire_next: assert property (@(posedge clk) disable iff (rst)
    strobe && (result.kind == stq_pkg::KIND_FIRED) |=> strobe)
    else $error("fired result not followed by a result");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sorted_timer_queue_top. Add, delete and run commands
// go in over the start/busy handshake; a scoreboard keeps its own sorted copy
// of the timer list, predicts every result and checks each strobed transfer
// field by field. A directed section hits the corner cases, then random
// sequences with full-queue flushes run under several sender idle patterns.
// ----------------------------------------------------------------------------
module testbench;

  localparam int SLOTS = 16;
  localparam logic [stq_pkg::OP_W-1:0] OP_UNDEF = 2'd3;

  // Scoreboard: sorted-list predictor plus the queue of results it owes
  class timer_queue_scoreboard;
    logic [stq_pkg::ID_W-1:0]   order_q[$];
    logic [stq_pkg::TIME_W-1:0] slot_exp[SLOTS];
    bit                         slot_on[SLOTS];
    logic [stq_pkg::TIME_W-1:0] mark;
    stq_pkg::result_t           awaited[$];
    int                         errors;

    function new();
      mark   = '0;
      errors = 0;
      foreach (slot_on[i]) slot_on[i] = 1'b0;
    endfunction

    function void owe(logic [stq_pkg::KIND_W-1:0] kind, logic [stq_pkg::ID_W-1:0] id,
                      logic [stq_pkg::TIME_W-1:0] tmo, logic fin);
      stq_pkg::result_t r;
      r.kind      = kind;
      r.fired_id  = id;
      r.time_left = tmo;
      r.last      = fin;
      awaited.push_back(r);
    endfunction

    // Drop the first list entry for this slot
    function void unlink(logic [stq_pkg::ID_W-1:0] id);
      for (int i = 0; i < order_q.size(); i++) begin
        if (order_q[i] == id) begin
          order_q.delete(i);
          break;
        end
      end
      slot_on[id] = 1'b0;
    endfunction

    // Expiry floored at mark + 1 (saturating), placed ahead of equal entries
    function void reschedule(logic [stq_pkg::ID_W-1:0] id,
                             logic [stq_pkg::TIME_W-1:0] exp);
      logic [stq_pkg::TIME_W-1:0] floor_t;
      int pos;
      if (slot_on[id]) unlink(id);
      floor_t = (mark == stq_pkg::TIME_MAX) ? stq_pkg::TIME_MAX : mark + 1;
      if (exp < floor_t) exp = floor_t;
      if (order_q.size() >= SLOTS) return;
      pos = 0;
      while (pos < order_q.size() && exp > slot_exp[order_q[pos]]) pos++;
      order_q.insert(pos, id);
      slot_exp[id] = exp;
      slot_on[id]  = 1'b1;
    endfunction

    function void run_expired(logic [stq_pkg::TIME_W-1:0] now);
      int                         fired;
      logic [stq_pkg::ID_W-1:0]   head;
      logic [stq_pkg::TIME_W-1:0] tmo;
      logic [stq_pkg::TIME_W-1:0] e;
      mark  = now;
      fired = 0;
      tmo   = '0;
      while (order_q.size() > 0 && fired < SLOTS) begin
        head = order_q[0];
        if (slot_exp[head] > now) break;
        unlink(head);
        owe(stq_pkg::KIND_FIRED, head, '0, 1'b0);
        fired++;
      end
      if (order_q.size() > 0) begin
        e   = slot_exp[order_q[0]];
        tmo = (e > now) ? e - now : 1;
      end
      owe(stq_pkg::KIND_RUN_DONE, '0, tmo, 1'b1);
    endfunction

    function void note_item(stq_pkg::item_t it);
      case (it.op)
        stq_pkg::OP_ADD: begin
          if (it.timer_id < SLOTS) reschedule(it.timer_id, it.expires);
          owe(stq_pkg::KIND_ADD_DONE, '0, '0, 1'b1);
        end
        stq_pkg::OP_DEL: begin
          if (it.timer_id < SLOTS && slot_on[it.timer_id]) unlink(it.timer_id);
          owe(stq_pkg::KIND_DEL_DONE, '0, '0, 1'b1);
        end
        stq_pkg::OP_RUN: run_expired(it.now);
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(stq_pkg::result_t got);
      stq_pkg::result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result with nothing pending: kind %0d id %0d tmo %0d last %0d",
                         got.kind, got.fired_id, got.time_left, got.last));
        return;
      end
      want = awaited.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.fired_id !== want.fired_id)
        report($sformatf("fired_id %0d, want %0d", got.fired_id, want.fired_id));
      if (got.time_left !== want.time_left)
        report($sformatf("time_left %0d, want %0d", got.time_left,
                         want.time_left));
      if (got.last !== want.last)
        report($sformatf("last %0d, want %0d", got.last, want.last));
    endtask
  endclass

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  stq_pkg::item_t   item;
  stq_pkg::result_t result;
  logic             strobe;

  timer_queue_scoreboard      sb;
  int                         idle_pct;
  logic [stq_pkg::TIME_W-1:0] wall;

  sorted_timer_queue_top #(.NUM_TIMERS(SLOTS)) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .result (result),
    .strobe (strobe)
  );

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Monitor: result transfers and accepted commands
  always @(posedge clk) begin
    if (!rst) begin
      if (strobe) sb.check_result(result);
      if (start && !busy) sb.note_item(item);
    end
  end

  // Entered and left at a falling edge; start stays high into the next call unless an idle gap is drawn
  task automatic drive_item(input stq_pkg::item_t it);
    start = 1'b1;
    item  = it;
    do @(posedge clk); while (busy);
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clk);
    end
  endtask

  task automatic do_add(input logic [stq_pkg::ID_W-1:0] id,
                        input logic [stq_pkg::TIME_W-1:0] exp);
    stq_pkg::item_t it;
    it.op       = stq_pkg::OP_ADD;
    it.timer_id = id;
    it.expires  = exp;
    it.now      = $urandom();
    drive_item(it);
  endtask

  task automatic do_del(input logic [stq_pkg::ID_W-1:0] id);
    stq_pkg::item_t it;
    it.op       = stq_pkg::OP_DEL;
    it.timer_id = id;
    it.expires  = $urandom();
    it.now      = $urandom();
    drive_item(it);
  endtask

  task automatic do_run(input logic [stq_pkg::TIME_W-1:0] now);
    stq_pkg::item_t it;
    it.op       = stq_pkg::OP_RUN;
    it.timer_id = stq_pkg::ID_W'($urandom());
    it.expires  = $urandom();
    it.now      = now;
    drive_item(it);
  endtask

  task automatic do_undef();
    stq_pkg::item_t it;
    it.op       = OP_UNDEF;
    it.timer_id = stq_pkg::ID_W'($urandom());
    it.expires  = $urandom();
    it.now      = $urandom();
    drive_item(it);
  endtask

  // Corner cases: empty run, absent delete, floors, ties, saturation
  task automatic run_directed();
    do_run('0);
    do_del(4'd5);
    do_add(4'd0, '0);
    do_add(4'd15, stq_pkg::TIME_MAX);
    do_add(4'd3, 32'd1);
    do_add(4'd0, 32'd100);
    do_undef();
    do_run(32'd1);
    do_del(4'd0);
    do_run(stq_pkg::TIME_MAX);
    do_add(4'd7, 32'd5);
    do_add(4'd8, stq_pkg::TIME_MAX);
    do_run(stq_pkg::TIME_MAX - 1);
    do_run(stq_pkg::TIME_MAX);
    do_run('0);
    do_add(4'd9, '0);
    do_add(4'd10, 32'h5555_AAAA);
    do_add(4'd6, 32'hAAAA_5555);
    do_del(4'd9);
    do_run(32'h7FFF_FFFF);
    do_run(stq_pkg::TIME_MAX);
  endtask

  // Fill every slot near the current time, then fire them all in one run
  task automatic fill_and_flush();
    logic [stq_pkg::ID_W-1:0] ids[SLOTS];
    logic [stq_pkg::ID_W-1:0] tmp;
    int                       j;
    foreach (ids[i]) ids[i] = stq_pkg::ID_W'(i);
    for (int i = SLOTS - 1; i > 0; i--) begin
      j      = $urandom_range(i);
      tmp    = ids[i];
      ids[i] = ids[j];
      ids[j] = tmp;
    end
    do_run(wall);
    foreach (ids[i]) do_add(ids[i], wall + 1 + $urandom_range(0, 8));
    wall = wall + 20;
    do_run(wall);
  endtask

  // Mostly plausible traffic around a moving clock, with some wild values
  task automatic random_phase(input int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 45) begin
        if ($urandom_range(9) == 0) do_add(stq_pkg::ID_W'($urandom()), $urandom());
        else do_add(stq_pkg::ID_W'($urandom()), wall + $urandom_range(0, 30));
      end else if (sel < 65) begin
        do_del(stq_pkg::ID_W'($urandom()));
      end else if (sel < 92) begin
        if ($urandom_range(9) == 0) wall = $urandom();
        else wall = wall + $urandom_range(0, 25);
        do_run(wall);
      end else begin
        do_undef();
      end
    end
    fill_and_flush();
  endtask

  initial begin
    sb       = new();
    rst      = 1'b1;
    start    = 1'b0;
    item     = '0;
    idle_pct = 0;
    wall     = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();
    wall = $urandom_range(1000, 100000);
    random_phase(12);
    idle_pct = 68;
    random_phase(12);
    idle_pct = 10;
    random_phase(8);
    idle_pct = 0;
    random_phase(5);

    // Drain, then give the block time to misbehave
    start = 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.awaited.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.awaited.size()));
    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
